@@ design/touch_grid_slider_swipe_classifier_top_macros.svh @@
// ----------------------------------------------------------------------------
// Touch grid classifier assertion macros
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GRID_SLIDER_SWIPE_CLASSIFIER_TOP_MACROS_SVH
`define TOUCH_GRID_SLIDER_SWIPE_CLASSIFIER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgs assertion failed");
`define TGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgs assertion failed");
`else
`define TGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/tgs_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch grid classifier package
// Shared types and constants of the touch grid, slider and swipe classifier.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int COORD_W  = 12;
    localparam int VOL_W    = 17;
    localparam int PORT_W   = 5;
    localparam int DIV_NUM_W = 28;
    localparam int DIV_CNT_W = 5;
    localparam int FRAC_W   = 16;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    localparam logic [PORT_W-1:0] PORT_VOLUME = 5'd18;
    localparam logic [PORT_W-1:0] PORT_LEFT   = 5'd19;
    localparam logic [PORT_W-1:0] PORT_RIGHT  = 5'd20;

    localparam logic [VOL_W-1:0] Q_ONE     = 17'h10000;
    localparam logic [VOL_W-1:0] VOL_RESET = 17'h08000;

    localparam logic [DIV_CNT_W-1:0] ITERS_CELL = 5'd12;
    localparam logic [DIV_CNT_W-1:0] ITERS_VOL  = 5'd28;

    localparam logic [COORD_W-1:0] RST_GRID_TOP     = 12'd90;
    localparam logic [COORD_W-1:0] RST_AREA_WIDTH   = 12'd1280;
    localparam logic [COORD_W-1:0] RST_AREA_HEIGHT  = 12'd630;
    localparam logic [COORD_W-1:0] RST_KEY_WIDTH    = 12'd213;
    localparam logic [COORD_W-1:0] RST_KEY_HEIGHT   = 12'd210;
    localparam logic [COORD_W-1:0] RST_SLIDER_WIDTH = 12'd0;
    localparam logic [VOL_W-1:0]   RST_VOLUME_STEP  = 17'd655;
    localparam logic [COORD_W-1:0] RST_SWIPE_MIN    = 12'd40;

    typedef enum logic [2:0] {
        CFG_GRID_TOP     = 3'd0,
        CFG_AREA_WIDTH   = 3'd1,
        CFG_AREA_HEIGHT  = 3'd2,
        CFG_KEY_WIDTH    = 3'd3,
        CFG_KEY_HEIGHT   = 3'd4,
        CFG_SLIDER_WIDTH = 3'd5,
        CFG_VOLUME_STEP  = 3'd6,
        CFG_SWIPE_MIN    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] grid_top;
        logic [COORD_W-1:0] area_width;
        logic [COORD_W-1:0] area_height;
        logic [COORD_W-1:0] key_width;
        logic [COORD_W-1:0] key_height;
        logic [COORD_W-1:0] slider_width;
        logic [VOL_W-1:0]   volume_step;
        logic [COORD_W-1:0] swipe_min_distance;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic               held;
        logic               press_started;
        logic               released;
    } t_sample;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              is_analog;
        logic              pressed;
        logic [VOL_W-1:0]  volume;
        logic              last;
    } t_event;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [COORD_W-1:0]   den;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ design/touch_grid_slider_swipe_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Touch grid, slider and swipe classifier
// Turns touch samples into grid key, volume and swipe events.
// Samples are taken one at a time: a new sample is accepted only in the idle state,
//   after the shared divider and the events of the last one are done;
//   output stalls back up through a 4-deep queue.
// Reset: registers to their defaults, volume one half, queue and flags cleared.
// ----------------------------------------------------------------------------
`include "touch_grid_slider_swipe_classifier_top_macros.svh"

module touch_grid_slider_swipe_classifier_top #(
    parameter int ROWS = 3,
    parameter int COLS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // touch_x[11:0], touch_y[23:12], held[24], press_started[25], released[26]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // port[4:0], pressed[5], volume[22:6]
    output logic [23:0] o_m_axis_tdata,
    // is_analog[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import tgs_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_sample w_sample;
    logic    w_push;
    t_event  w_push_event;
    t_event  w_q_event;
    t_q_stat w_qstat;
    logic    w_pop;
    t_event  w_out_event;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GRID_TOP:     n_cfg.grid_top           = i_cfg_wdata[COORD_W-1:0];
                CFG_AREA_WIDTH:   n_cfg.area_width         = i_cfg_wdata[COORD_W-1:0];
                CFG_AREA_HEIGHT:  n_cfg.area_height        = i_cfg_wdata[COORD_W-1:0];
                CFG_KEY_WIDTH:    n_cfg.key_width          = i_cfg_wdata[COORD_W-1:0];
                CFG_KEY_HEIGHT:   n_cfg.key_height         = i_cfg_wdata[COORD_W-1:0];
                CFG_SLIDER_WIDTH: n_cfg.slider_width       = i_cfg_wdata[COORD_W-1:0];
                CFG_VOLUME_STEP:  n_cfg.volume_step        = i_cfg_wdata;
                CFG_SWIPE_MIN:    n_cfg.swipe_min_distance = i_cfg_wdata[COORD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_top           <= RST_GRID_TOP;
            r_cfg.area_width         <= RST_AREA_WIDTH;
            r_cfg.area_height        <= RST_AREA_HEIGHT;
            r_cfg.key_width          <= RST_KEY_WIDTH;
            r_cfg.key_height         <= RST_KEY_HEIGHT;
            r_cfg.slider_width       <= RST_SLIDER_WIDTH;
            r_cfg.volume_step        <= RST_VOLUME_STEP;
            r_cfg.swipe_min_distance <= RST_SWIPE_MIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_sample.touch_x       = i_s_axis_tdata[11:0];
    assign w_sample.touch_y       = i_s_axis_tdata[23:12];
    assign w_sample.held          = i_s_axis_tdata[24];
    assign w_sample.press_started = i_s_axis_tdata[25];
    assign w_sample.released      = i_s_axis_tdata[26];

    tgs_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample (w_sample),
        .o_push   (w_push),
        .o_event  (w_push_event),
        .i_qstat  (w_qstat)
    );

    tgs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_event),
        .i_pop   (w_pop),
        .o_rdata (w_q_event),
        .o_stat  (w_qstat)
    );

    tgs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (w_q_event),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_event (w_out_event)
    );

    assign o_m_axis_tdata = {1'b0, w_out_event.volume, w_out_event.pressed, w_out_event.port};
    assign o_m_axis_tuser = w_out_event.is_analog;
    assign o_m_axis_tlast = w_out_event.last;

    `TGS_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, !w_qstat.full)
    `TGS_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    `TGS_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

@@ design/tgs_div.sv @@
// ----------------------------------------------------------------------------
// Touch grid classifier divider
// Restoring divider, one quotient bit per cycle over a chosen bit count.
// ----------------------------------------------------------------------------
module tgs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tgs_pkg::t_div_req                 i_req,
    output logic                              o_done,
    output logic [tgs_pkg::DIV_NUM_W-1:0]     o_quo
);
    import tgs_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [COORD_W-1:0]   r_rem, n_rem;
    logic [COORD_W-1:0]   r_den, n_den;

    logic [COORD_W:0]     w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_num  = i_req.num;
            n_quo  = '0;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_ge ? COORD_W'(w_trial - {1'b0, r_den}) : w_trial[COORD_W-1:0];
            n_num = {r_num[DIV_NUM_W-2:0], 1'b0};
            n_quo = {r_quo[DIV_NUM_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ design/tgs_front.sv @@
// ----------------------------------------------------------------------------
// Touch grid classifier front end
// Takes one touch sample, classifies it and queues the resulting events.
// ----------------------------------------------------------------------------
module tgs_front #(
    parameter int ROWS = 3,
    parameter int COLS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgs_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  tgs_pkg::t_sample  i_sample,
    output logic              o_push,
    output tgs_pkg::t_event   o_event,
    input  tgs_pkg::t_q_stat  i_qstat
);
    import tgs_pkg::*;

    typedef enum logic [6:0] {
        FS_IDLE   = 7'b0000001,
        FS_DECIDE = 7'b0000010,
        FS_COL    = 7'b0000100,
        FS_ROW    = 7'b0001000,
        FS_VOL    = 7'b0010000,
        FS_FIN    = 7'b0100000,
        FS_EMIT   = 7'b1000000
    } t_fstate;

    t_fstate              r_state, n_state;

    logic [COORD_W-1:0]   r_x, n_x;
    logic [COORD_W-1:0]   r_y, n_y;
    logic                 r_held, n_held;
    logic                 r_st, n_st;
    logic                 r_rel, n_rel;

    logic [VOL_W-1:0]     r_cur_vol, n_cur_vol;
    logic                 r_grid_held, n_grid_held;
    logic [PORT_W-1:0]    r_held_port, n_held_port;
    logic                 r_slider_held, n_slider_held;
    logic                 r_armed, n_armed;
    logic [COORD_W-1:0]   r_sx, n_sx;
    logic [COORD_W-1:0]   r_sy, n_sy;

    logic                 r_grid_try, n_grid_try;
    logic                 r_vol_try, n_vol_try;
    logic [COORD_W-1:0]   r_col, n_col;
    logic [COORD_W-1:0]   r_row, n_row;
    logic [VOL_W-1:0]     r_nv, n_nv;
    logic [3:0]           r_mask, n_mask;
    logic [PORT_W-1:0]    r_p0, n_p0;
    logic                 r_a0, n_a0;
    logic [VOL_W-1:0]     r_v0, n_v0;
    logic [PORT_W-1:0]    r_p1, n_p1;
    logic [PORT_W-1:0]    r_sp, n_sp;

    t_div_req             w_req;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quo;

    logic [COORD_W:0]     w_band_end;
    logic                 w_in_band;
    logic                 w_grid_pre;
    logic                 w_slider;
    logic                 w_track;
    logic signed [13:0]   w_n;
    logic                 w_vol_direct;
    logic [VOL_W-1:0]     w_vol_direct_val;
    logic [COORD_W-1:0]   w_row_num;

    logic [31:0]          w_cell_full;
    logic [PORT_W-1:0]    w_cell;
    logic                 w_cell_ok;
    logic [VOL_W-1:0]     w_vdiff;
    logic                 w_track_rep;
    logic                 w_gh1;
    logic [PORT_W-1:0]    w_hp1;
    logic                 w_sh1;
    logic signed [12:0]   w_dx;
    logic signed [12:0]   w_dy;
    logic [12:0]          w_adx;
    logic [12:0]          w_ady;
    logic                 w_swipe;
    logic [3:0]           w_sel;

    tgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_band_end = {1'b0, i_cfg.grid_top} + {1'b0, i_cfg.area_height};
    assign w_in_band  = (r_y >= i_cfg.grid_top) && ({1'b0, r_y} < w_band_end);
    assign w_grid_pre = r_st && (i_cfg.key_width != '0) && (i_cfg.key_height != '0)
                        && w_in_band && (r_x < i_cfg.area_width);
    assign w_slider   = r_st && (i_cfg.slider_width != '0) && (r_x >= i_cfg.area_width)
                        && w_in_band;
    assign w_track    = !r_st && r_slider_held && r_held;
    assign w_row_num  = r_y - i_cfg.grid_top;

    assign w_n = $signed({2'b00, i_cfg.grid_top}) + $signed({2'b00, i_cfg.area_height})
                 - $signed({2'b00, r_y});

    always_comb begin
        w_vol_direct     = 1'b1;
        w_vol_direct_val = r_cur_vol;
        priority if (i_cfg.area_height == '0) begin
            w_vol_direct_val = r_cur_vol;
        end else if (w_n <= 14'sd0) begin
            w_vol_direct_val = '0;
        end else if (w_n >= $signed({2'b00, i_cfg.area_height})) begin
            w_vol_direct_val = Q_ONE;
        end else begin
            w_vol_direct = 1'b0;
        end
    end

    assign w_cell_full = 32'(r_row) * 32'(COLS) + 32'(r_col);
    assign w_cell      = w_cell_full[PORT_W-1:0];
    assign w_cell_ok   = r_grid_try && (r_col < COORD_W'(COLS)) && (r_row < COORD_W'(ROWS));
    assign w_vdiff     = (r_nv > r_cur_vol) ? (r_nv - r_cur_vol) : (r_cur_vol - r_nv);
    assign w_track_rep = !r_st && r_vol_try && (w_vdiff > i_cfg.volume_step);
    assign w_gh1       = r_st ? w_cell_ok : r_grid_held;
    assign w_hp1       = r_st ? (w_cell_ok ? w_cell : '0) : r_held_port;
    assign w_sh1       = r_st ? (!w_cell_ok && r_vol_try) : r_slider_held;

    assign w_dx    = $signed({1'b0, r_x}) - $signed({1'b0, r_sx});
    assign w_dy    = $signed({1'b0, r_y}) - $signed({1'b0, r_sy});
    assign w_adx   = w_dx[12] ? 13'(-w_dx) : 13'(w_dx);
    assign w_ady   = w_dy[12] ? 13'(-w_dy) : 13'(w_dy);
    assign w_swipe = !r_st && r_rel && r_armed && (w_adx > {1'b0, i_cfg.swipe_min_distance})
                     && (w_adx > w_ady);

    assign w_sel = r_mask & (~r_mask + 4'd1);

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_y           = r_y;
        n_held        = r_held;
        n_st          = r_st;
        n_rel         = r_rel;
        n_cur_vol     = r_cur_vol;
        n_grid_held   = r_grid_held;
        n_held_port   = r_held_port;
        n_slider_held = r_slider_held;
        n_armed       = r_armed;
        n_sx          = r_sx;
        n_sy          = r_sy;
        n_grid_try    = r_grid_try;
        n_vol_try     = r_vol_try;
        n_col         = r_col;
        n_row         = r_row;
        n_nv          = r_nv;
        n_mask        = r_mask;
        n_p0          = r_p0;
        n_a0          = r_a0;
        n_v0          = r_v0;
        n_p1          = r_p1;
        n_sp          = r_sp;
        w_req         = '0;
        o_push        = 1'b0;
        o_event       = '0;
        unique case (r_state)
            FS_IDLE: begin
                if (i_valid) begin
                    n_x     = i_sample.touch_x;
                    n_y     = i_sample.touch_y;
                    n_held  = i_sample.held;
                    n_st    = i_sample.press_started;
                    n_rel   = i_sample.released;
                    n_state = FS_DECIDE;
                end
            end
            FS_DECIDE: begin
                n_grid_try = w_grid_pre;
                n_vol_try  = !w_grid_pre && (w_slider || w_track);
                if (w_grid_pre) begin
                    w_req.start = 1'b1;
                    w_req.num   = {r_x, {FRAC_W{1'b0}}};
                    w_req.den   = i_cfg.key_width;
                    w_req.iters = ITERS_CELL;
                    n_state     = FS_COL;
                end else if (w_slider || w_track) begin
                    if (w_vol_direct) begin
                        n_nv    = w_vol_direct_val;
                        n_state = FS_FIN;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.num   = {w_n[COORD_W-1:0], {FRAC_W{1'b0}}};
                        w_req.den   = i_cfg.area_height;
                        w_req.iters = ITERS_VOL;
                        n_state     = FS_VOL;
                    end
                end else begin
                    n_state = FS_FIN;
                end
            end
            FS_COL: begin
                if (w_div_done) begin
                    n_col       = w_quo[COORD_W-1:0];
                    w_req.start = 1'b1;
                    w_req.num   = {w_row_num, {FRAC_W{1'b0}}};
                    w_req.den   = i_cfg.key_height;
                    w_req.iters = ITERS_CELL;
                    n_state     = FS_ROW;
                end
            end
            FS_ROW: begin
                if (w_div_done) begin
                    n_row   = w_quo[COORD_W-1:0];
                    n_state = FS_FIN;
                end
            end
            FS_VOL: begin
                if (w_div_done) begin
                    n_nv    = w_quo[VOL_W-1:0];
                    n_state = FS_FIN;
                end
            end
            FS_FIN: begin
                n_mask[0] = r_st ? (w_cell_ok || r_vol_try) : w_track_rep;
                n_mask[1] = r_rel && w_gh1;
                n_mask[2] = w_swipe;
                n_mask[3] = w_swipe;
                n_p0      = w_cell_ok ? w_cell : PORT_VOLUME;
                n_a0      = !w_cell_ok;
                n_v0      = w_cell_ok ? '0 : r_nv;
                n_p1      = w_hp1;
                n_sp      = w_dx[12] ? PORT_LEFT : PORT_RIGHT;
                if ((r_st && r_vol_try) || w_track_rep) begin
                    n_cur_vol = r_nv;
                end
                n_grid_held   = r_rel ? 1'b0 : w_gh1;
                n_held_port   = r_rel ? '0 : w_hp1;
                n_slider_held = r_rel ? 1'b0 : w_sh1;
                if (r_st) begin
                    n_armed = (r_y >= i_cfg.grid_top) && (r_x < i_cfg.area_width);
                    n_sx    = r_x;
                    n_sy    = r_y;
                end else if (r_rel) begin
                    n_armed = 1'b0;
                end
                n_state = (n_mask != '0) ? FS_EMIT : FS_IDLE;
            end
            FS_EMIT: begin
                if (!i_qstat.full) begin
                    o_push       = 1'b1;
                    o_event.last = (r_mask & ~w_sel) == '0;
                    priority if (w_sel[0]) begin
                        o_event.port      = r_p0;
                        o_event.is_analog = r_a0;
                        o_event.pressed   = !r_a0;
                        o_event.volume    = r_v0;
                    end else if (w_sel[1]) begin
                        o_event.port      = r_p1;
                    end else if (w_sel[2]) begin
                        o_event.port      = r_sp;
                        o_event.pressed   = 1'b1;
                    end else begin
                        o_event.port      = r_sp;
                    end
                    n_mask = r_mask & ~w_sel;
                    if (n_mask == '0) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= FS_IDLE;
            r_cur_vol     <= VOL_RESET;
            r_grid_held   <= 1'b0;
            r_held_port   <= '0;
            r_slider_held <= 1'b0;
            r_armed       <= 1'b0;
            r_sx          <= '0;
            r_sy          <= '0;
            r_mask        <= '0;
        end else begin
            r_state       <= n_state;
            r_cur_vol     <= n_cur_vol;
            r_grid_held   <= n_grid_held;
            r_held_port   <= n_held_port;
            r_slider_held <= n_slider_held;
            r_armed       <= n_armed;
            r_sx          <= n_sx;
            r_sy          <= n_sy;
            r_mask        <= n_mask;
        end
        r_x        <= n_x;
        r_y        <= n_y;
        r_held     <= n_held;
        r_st       <= n_st;
        r_rel      <= n_rel;
        r_grid_try <= n_grid_try;
        r_vol_try  <= n_vol_try;
        r_col      <= n_col;
        r_row      <= n_row;
        r_nv       <= n_nv;
        r_p0       <= n_p0;
        r_a0       <= n_a0;
        r_v0       <= n_v0;
        r_p1       <= n_p1;
        r_sp       <= n_sp;
    end

    assign o_ready = (r_state == FS_IDLE);

endmodule

@@ design/tgs_fifo.sv @@
// ----------------------------------------------------------------------------
// Touch grid classifier event queue
// Short queue of events between the classifier and the output stage.
// ----------------------------------------------------------------------------
module tgs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tgs_pkg::t_event   i_wdata,
    input  logic              i_pop,
    output tgs_pkg::t_event   o_rdata,
    output tgs_pkg::t_q_stat  o_stat
);
    import tgs_pkg::*;

    t_event               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

@@ design/tgs_back.sv @@
// ----------------------------------------------------------------------------
// Touch grid classifier output stage
// Moves queued events into the output register and holds them until taken.
// ----------------------------------------------------------------------------
module tgs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgs_pkg::t_event   i_rdata,
    input  tgs_pkg::t_q_stat  i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tgs_pkg::t_event   o_event
);
    import tgs_pkg::*;

    logic   r_valid, n_valid;
    t_event r_event, n_event;

    always_comb begin
        o_pop   = !i_qstat.empty && (!r_valid || i_ready);
        n_valid = r_valid;
        n_event = r_event;
        if (o_pop) begin
            n_valid = 1'b1;
            n_event = i_rdata;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_event <= n_event;
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule
